>>> hw/rtl/wbps_pkg.sv
// wbps_pkg: sizes, word types and cell control for the wildcard byte pattern search
// no dependencies; imported by wbps_cell and wildcard_byte_pattern_search
package wbps_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int OFF_W       = 20;
  localparam int LEN_W       = 7;
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CMP_W       = (LEN_W > IDX_W + 1) ? LEN_W : IDX_W + 1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [5:0] entry_index;
    logic [7:0] byte_value;
    logic       is_wildcard;
    logic       last_byte;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [19:0] match_offset;
  } rsp_t;

  typedef struct packed {
    logic wr;
    logic in_use;
    logic is_top;
    logic adv;
    logic clr;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/wbps_cell.sv
// wbps_cell: one pattern position with its byte, wildcard mark and match bit
// depends on wbps_pkg
module wbps_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wbps_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          pat_byte_i,
  input  logic                pat_wild_i,
  input  logic [7:0]          data_byte_i,
  input  logic                prev_i,
  output logic                bit_o,
  output logic                hit_o
);
  import wbps_pkg::*;

  logic [7:0] pat_q;
  logic       wild_q;
  logic       bit_q, bit_d;
  logic       next_bit;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      pat_q  <= pat_byte_i;
      wild_q <= pat_wild_i;
    end
  end

  assign next_bit = prev_i & ctrl_i.in_use & (wild_q | (pat_q == data_byte_i));

  always_comb begin
    bit_d = bit_q;
    if (ctrl_i.clr) begin
      bit_d = 1'b0;
    end else if (ctrl_i.adv) begin
      bit_d = next_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;
  assign hit_o = next_bit & ctrl_i.is_top;

endmodule

>>> hw/rtl/wildcard_byte_pattern_search.sv
// wildcard_byte_pattern_search: top level, row of match cells plus result buffer
// depends on wbps_pkg and wbps_cell
//
//  channel  direction  handshake               word
//  in       input      in_valid_i/in_stall_o   req_t
//  out      output     out_valid_o/out_stall_i rsp_t
//  cfg      input      cfg_we_i                pattern_length
//
// one word accepted per cycle unless stalled; each result is registered in the output or skid word
// each cell compares its byte and hands its match bit to the next cell on each advancing data byte
// a two-word output buffer keeps input flowing while a result waits
// the input stalls only while both output words are held
// reset clears length, match bits, position, report flag and buffer; pattern cells hold garbage until loaded
module wildcard_byte_pattern_search (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [6:0]               cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  wbps_pkg::req_t           in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output wbps_pkg::rsp_t           out_data_o
);
  import wbps_pkg::*;

  logic [LEN_W-1:0]       len_q;
  logic [OFF_W-1:0]       pos_q, pos_d;
  logic                   rep_q, rep_d;
  logic [MAX_PATTERN-1:0] vec, hits;
  cell_ctrl_t             ctrl [MAX_PATTERN];

  logic in_acc, data_acc, load_acc, len_ok, adv, clr, hit_now;
  logic [OFF_W-1:0] off;
  logic res_v;
  rsp_t res;

  rsp_t out_q, skid_q;
  logic out_v_q, skid_v_q, out_take;

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign data_acc = in_acc & (in_data_i.req_type == REQ_DATA);
  assign load_acc = in_acc & (in_data_i.req_type == REQ_LOAD);
  assign len_ok   = (len_q != '0) && (CMP_W'(len_q) <= CMP_W'(MAX_PATTERN));
  assign adv      = data_acc & ~rep_q & len_ok;
  assign clr      = data_acc & (in_data_i.last_byte | (~rep_q & ~len_ok));

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic prev;
    if (i == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_rest
      assign prev = vec[i-1];
    end

    assign ctrl[i].wr     = load_acc &&
                            (CMP_W'(in_data_i.entry_index) == CMP_W'(i));
    assign ctrl[i].in_use = CMP_W'(i) < CMP_W'(len_q);
    assign ctrl[i].is_top = CMP_W'(i + 1) == CMP_W'(len_q);
    assign ctrl[i].adv    = adv;
    assign ctrl[i].clr    = clr;

    wbps_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl[i]),
      .pat_byte_i  (in_data_i.byte_value),
      .pat_wild_i  (in_data_i.is_wildcard),
      .data_byte_i (in_data_i.byte_value),
      .prev_i      (prev),
      .bit_o       (vec[i]),
      .hit_o       (hits[i])
    );
  end

  assign hit_now = adv & (|hits);
  assign off     = pos_q - OFF_W'(len_q - 7'd1);

  always_comb begin
    res_v              = data_acc & (hit_now | (in_data_i.last_byte & ~rep_q));
    res.found          = hit_now;
    res.match_offset   = hit_now ? 20'(off) : 20'd0;
    pos_d = pos_q;
    rep_d = rep_q;
    if (data_acc) begin
      if (in_data_i.last_byte) begin
        pos_d = '0;
        rep_d = 1'b0;
      end else begin
        pos_d = pos_q + OFF_W'(1);
        rep_d = rep_q | hit_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      pos_q <= '0;
      rep_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      pos_q <= pos_d;
      rep_q <= rep_d;
    end
  end

  // output word plus skid word
  assign out_take = out_v_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || out_take) begin
        if (skid_v_q) begin
          out_v_q  <= 1'b1;
          skid_v_q <= 1'b0;
        end else begin
          out_v_q  <= res_v;
        end
      end else if (res_v) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_take) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (res_v) begin
      skid_q <= res;
    end
  end

  assign in_stall_o  = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid word held without output word");

  a_chunk_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (data_acc && in_data_i.last_byte) |=> (vec == '0 && pos_q == '0 && !rep_q))
    else $error("chunk state not cleared after last byte");

  a_vec_frozen_after_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (data_acc && rep_q && !in_data_i.last_byte) |=> $stable(vec))
    else $error("match vector moved after a reported match");

endmodule
